### rtl/core/pau_pkg.sv
// Shared types and constants for the Pareto archive update block.
// No dependencies; imported by pareto_archive_update and pau_cmp.
package pau_pkg;

   localparam int OBJ_W    = 32;  // one objective, unsigned 24.8
   localparam int MAX_OBJ  = 4;   // objective ports on the request channel
   localparam int HANDLE_W = 16;  // payload handle
   localparam int COUNT_W  = 7;   // reported counts

   // Dominance relation of a candidate against one stored entry
   typedef struct packed {
      logic cand_no_worse;   // candidate <= entry in every objective
      logic entry_no_worse;  // entry <= candidate in every objective
   } dom_type;

endpackage

### rtl/core/pareto_archive_update.sv
// Pareto archive update: keeps an ordered archive of non-dominated objective
// vectors (all minimized) and reports, for each candidate, whether it entered.
// Request channel (req_*): candidate objectives a..d plus a payload handle;
// a transfer happens when req_valid is high and req_stall is low. Only the
// first NUM_OBJECTIVES objectives are compared and stored.
// Response channel (rsp_*): one result per request: accepted, removed_count,
// entry_count, overflow; transfer on rsp_valid high and rsp_stall low.
// Sequence: a request holds the block while it captures the candidate, streams
// one archive read per stored entry through the single read port of the entry
// memory, waits out the read latency, sees the scan end, and then appends and
// posts the result. The archive is compacted in place during that scan.
// The result sits in an output register, so the next request is taken while
// it waits; a new result is held back only while the previous one is stalled.
// Reset (synchronous) empties the archive by zeroing the occupancy count;
// the memory itself is not cleared. req_stall is high during reset.
// Depends on pau_pkg, pau_cmp, pau_store.
module pareto_archive_update #(
   parameter int ARCHIVE_DEPTH  = 64,
   parameter int NUM_OBJECTIVES = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pau_pkg::OBJ_W-1:0]    req_objective_a,
   input  logic [pau_pkg::OBJ_W-1:0]    req_objective_b,
   input  logic [pau_pkg::OBJ_W-1:0]    req_objective_c,
   input  logic [pau_pkg::OBJ_W-1:0]    req_objective_d,
   input  logic [pau_pkg::HANDLE_W-1:0] req_payload_handle,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_accepted,
   output logic [pau_pkg::COUNT_W-1:0]  rsp_removed_count,
   output logic [pau_pkg::COUNT_W-1:0]  rsp_entry_count,
   output logic                         rsp_overflow
);
   import pau_pkg::*;

   localparam int OBJS_W  = NUM_OBJECTIVES * OBJ_W;
   localparam int ENTRY_W = OBJS_W + HANDLE_W;        // {handle, objectives}
   localparam int AW      = $clog2(ARCHIVE_DEPTH);
   localparam int CW      = $clog2(ARCHIVE_DEPTH + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        occ_ff, occ_in;          // valid entries 0..occ-1
   logic [CW-1:0]        rd_ptr_ff, rd_ptr_in;    // next entry to read
   logic [CW-1:0]        wr_ptr_ff, wr_ptr_in;    // next compacted slot
   logic [CW-1:0]        removed_ff, removed_in;
   logic                 rejected_ff, rejected_in;
   logic                 pend_ff, pend_in;        // read data valid this cycle
   logic [OBJS_W-1:0]    cand_objs_ff, cand_objs_in;
   logic [HANDLE_W-1:0]  cand_handle_ff, cand_handle_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_acc_ff, rsp_acc_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic [COUNT_W-1:0]   rsp_removed_ff, rsp_removed_in;
   logic [COUNT_W-1:0]   rsp_entries_ff, rsp_entries_in;

   logic [MAX_OBJ*OBJ_W-1:0] req_objs_all;
   logic                 mem_re, mem_we;
   logic [ENTRY_W-1:0]   mem_wdata, mem_rdata;
   dom_type              dom;
   logic                 drop, keep_wr, reject_now, done_go, full, append;

   assign req_objs_all = {req_objective_d, req_objective_c,
                          req_objective_b, req_objective_a};

   // ---------------------------------------------------------------
   // Scan datapath: read stream at rd_ptr, compacting writes at wr_ptr.
   // wr_ptr never passes rd_ptr, so a write never hits an entry that is
   // still to be read: no forwarding needed.
   // ---------------------------------------------------------------
   pau_cmp #(.NUM_OBJECTIVES(NUM_OBJECTIVES)) u_cmp (
      .cand_objs  (cand_objs_ff),
      .entry_objs (mem_rdata[OBJS_W-1:0]),
      .dom        (dom)
   );

   always_comb begin
      mem_re     = (state_ff == ST_SCAN) && (rd_ptr_ff != occ_ff);
      // Once rejected, remaining entries are only copied down
      drop       = pend_ff && !rejected_ff && dom.cand_no_worse;
      keep_wr    = pend_ff && !drop;
      reject_now = keep_wr && !rejected_ff && dom.entry_no_worse;
      done_go    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
      full       = (wr_ptr_ff == CW'(ARCHIVE_DEPTH));
      append     = done_go && !rejected_ff && !full;
      mem_we     = keep_wr || append;
      mem_wdata  = append ? {cand_handle_ff, cand_objs_ff} : mem_rdata;
   end

   pau_store #(.DEPTH(ARCHIVE_DEPTH), .WIDTH(ENTRY_W), .ADDR_W(AW)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_ptr_ff[AW-1:0]),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (mem_rdata)
   );

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      occ_in         = occ_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      removed_in     = removed_ff;
      rejected_in    = rejected_ff;
      pend_in        = 1'b0;
      cand_objs_in   = cand_objs_ff;
      cand_handle_in = cand_handle_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_acc_in     = rsp_acc_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_entries_in = rsp_entries_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rd_ptr_in      = '0;
               wr_ptr_in      = '0;
               removed_in     = '0;
               rejected_in    = 1'b0;
               cand_objs_in   = req_objs_all[OBJS_W-1:0];
               cand_handle_in = req_payload_handle;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pend_in     = mem_re;
            rd_ptr_in   = rd_ptr_ff + CW'(mem_re);
            wr_ptr_in   = wr_ptr_ff + CW'(keep_wr);
            removed_in  = removed_ff + CW'(drop);
            rejected_in = rejected_ff || reject_now;
            if (!mem_re && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_go) begin
               occ_in         = wr_ptr_ff + CW'(append);
               rsp_valid_in   = 1'b1;
               rsp_acc_in     = append;
               rsp_ovf_in     = !rejected_ff && full;
               rsp_removed_in = COUNT_W'(removed_ff);
               rsp_entries_in = COUNT_W'(wr_ptr_ff + CW'(append));
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         removed_ff   <= '0;
         rejected_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         removed_ff   <= removed_in;
         rejected_ff  <= rejected_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_objs_ff   <= cand_objs_in;
      cand_handle_ff <= cand_handle_in;
      rsp_acc_ff     <= rsp_acc_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_entries_ff <= rsp_entries_in;
   end

   assign req_stall         = reset || (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_overflow      = rsp_ovf_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_entry_count   = rsp_entries_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // Compaction writes must trail the read stream
   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff <= rd_ptr_ff)
      else $error("write pointer ahead of read pointer");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(ARCHIVE_DEPTH))
      else $error("occupancy beyond archive depth");

   a_acc_ovf_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_acc_ff && rsp_ovf_ff))
      else $error("result both accepted and overflowed");

   // Archive only changes size when a result is posted
   a_occ_on_result: assert property (@(posedge clock) disable iff (reset)
      !done_go |=> $stable(occ_ff))
      else $error("occupancy changed outside result posting");

endmodule

### rtl/core/pau_store.sv
// Archive entry memory: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module pau_store #(
   parameter int DEPTH   = 64,
   parameter int WIDTH   = 144,
   parameter int ADDR_W  = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/pau_cmp.sv
// Dominance compare of a candidate vector against one archive entry.
// Depends on pau_pkg (OBJ_W, dom_type).
module pau_cmp #(
   parameter int NUM_OBJECTIVES = 4
) (
   input  logic [NUM_OBJECTIVES*pau_pkg::OBJ_W-1:0] cand_objs,
   input  logic [NUM_OBJECTIVES*pau_pkg::OBJ_W-1:0] entry_objs,
   output pau_pkg::dom_type                         dom
);
   import pau_pkg::*;

   logic [NUM_OBJECTIVES-1:0] cand_gt;
   logic [NUM_OBJECTIVES-1:0] cand_lt;

   always_comb begin
      for (int k = 0; k < NUM_OBJECTIVES; k++) begin
         cand_gt[k] = cand_objs[k*OBJ_W +: OBJ_W] > entry_objs[k*OBJ_W +: OBJ_W];
         cand_lt[k] = cand_objs[k*OBJ_W +: OBJ_W] < entry_objs[k*OBJ_W +: OBJ_W];
      end
      dom.cand_no_worse  = ~|cand_gt;
      dom.entry_no_worse = ~|cand_lt;
   end

endmodule
